/* hw/rtl/sd_pkg.sv */
package sd_pkg;

   // default widths of the sample fields and the step counter
   localparam int SAMPLE_BITS_DEF = 13;
   localparam int COUNT_BITS_DEF  = 24;

   // register widths
   localparam int XTH_BITS = 12;
   localparam int YZ_BITS  = 8;
   localparam int ADJ_BITS = 4;
   localparam int THR_BITS = 9;

   // adaptive threshold constants
   localparam int BIG_MARGIN = 200;
   localparam int YZ_RESET   = 185;

   // reset values of the configuration registers
   localparam int XTH_RESET    = 35;
   localparam int YZ_MIN_RESET = 175;
   localparam int YZ_MAX_RESET = 195;
   localparam int ADJ_RESET    = 2;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = XTH_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_X_THRESHOLD = 2'd0,
      CSR_YZ_MIN      = 2'd1,
      CSR_YZ_MAX      = 2'd2,
      CSR_ADJUST_STEP = 2'd3
   } csr_reg_type;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // upper bound that an adaptive threshold never exceeds
   localparam int THR_LIMIT = 255 + 15;

   // lane results and beat control handed to the merge stage
   typedef struct packed {
      logic fire;
      logic clear;
      logic vib;
      logic vx;
      logic vy;
      logic vz;
   } merge_ctrl_type;

endpackage

/* hw/rtl/accel_step_detector_unit.sv */
// Step detector for a three-axis accelerometer stream. Each req beat carries one
// sample (or a clear of the step count) and yields exactly one rsp beat with the
// running count and whether this sample was a step. One beat is taken every
// cycle the slot is free; the result appears in the cycle after acceptance, from
// the single result register, and a new beat is taken while that register drains.
// Three axis lanes compute the magnitude change in parallel, the y and z lanes
// adapt their thresholds, and a merge stage decides the step and updates the
// count. No clearing pass after reset: the block takes beats from the first cycle.
module accel_step_detector_unit #(
   parameter int SAMPLE_BITS = sd_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = sd_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [SAMPLE_BITS-1:0]       req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0]       req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0]       req_accel_z,
   input  logic                                req_vibrating,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [COUNT_BITS-1:0]               rsp_step_count,
   output logic                                rsp_step_detected,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sd_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import sd_pkg::*;

   localparam int XW = SAMPLE_BITS > XTH_BITS ? SAMPLE_BITS : XTH_BITS;

   logic [XTH_BITS-1:0]    x_thr_ff;
   logic [YZ_BITS-1:0]     yz_min_ff;
   logic [YZ_BITS-1:0]     yz_max_ff;
   logic [ADJ_BITS-1:0]    adj_ff;
   logic                   req_fire;
   logic                   lane_en;
   logic                   slot_free;
   logic [SAMPLE_BITS-1:0] mag_x;
   logic [SAMPLE_BITS-1:0] mag_y;
   logic [SAMPLE_BITS-1:0] mag_z;
   logic                   vx;
   logic                   vy;
   logic                   vz;
   logic [THR_BITS-1:0]    y_thr;
   logic [THR_BITS-1:0]    z_thr;
   merge_ctrl_type         ctrl;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_thr_ff  <= XTH_BITS'(XTH_RESET);
         yz_min_ff <= YZ_BITS'(YZ_MIN_RESET);
         yz_max_ff <= YZ_BITS'(YZ_MAX_RESET);
         adj_ff    <= ADJ_BITS'(ADJ_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            CSR_X_THRESHOLD: x_thr_ff  <= csr_data[XTH_BITS-1:0];
            CSR_YZ_MIN:      yz_min_ff <= csr_data[YZ_BITS-1:0];
            CSR_YZ_MAX:      yz_max_ff <= csr_data[YZ_BITS-1:0];
            CSR_ADJUST_STEP: adj_ff    <= csr_data[ADJ_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input handshake
   assign req_ready = slot_free;
   assign req_fire  = req_valid && req_ready;
   assign lane_en   = req_fire && (req_op == OP_SAMPLE);

   // axis lanes
   sd_mag_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
      .clock(clock), .reset(reset), .en(lane_en),
      .sample(req_accel_x), .mag_change(mag_x)
   );

   sd_mag_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
      .clock(clock), .reset(reset), .en(lane_en),
      .sample(req_accel_y), .mag_change(mag_y)
   );

   sd_mag_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
      .clock(clock), .reset(reset), .en(lane_en),
      .sample(req_accel_z), .mag_change(mag_z)
   );

   // x uses the fixed threshold
   assign vx = XW'(mag_x) >= XW'(x_thr_ff);

   sd_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_adapt_y (
      .clock(clock), .reset(reset), .en(lane_en), .mag_change(mag_y),
      .yz_min(yz_min_ff), .yz_max(yz_max_ff), .adjust_step(adj_ff),
      .qualify(vy), .threshold(y_thr)
   );

   sd_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_adapt_z (
      .clock(clock), .reset(reset), .en(lane_en), .mag_change(mag_z),
      .yz_min(yz_min_ff), .yz_max(yz_max_ff), .adjust_step(adj_ff),
      .qualify(vz), .threshold(z_thr)
   );

   // merge stage
   always_comb begin
      ctrl.fire  = req_fire;
      ctrl.clear = req_op == OP_CLEAR;
      ctrl.vib   = req_vibrating;
      ctrl.vx    = vx;
      ctrl.vy    = vy;
      ctrl.vz    = vz;
   end

   sd_merge #(.COUNT_BITS(COUNT_BITS)) u_merge (
      .clock(clock), .reset(reset), .ctrl(ctrl), .rsp_ready(rsp_ready),
      .slot_free(slot_free), .rsp_valid(rsp_valid),
      .rsp_step_count(rsp_step_count), .rsp_step_detected(rsp_step_detected)
   );

   // checks
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_CLEAR)
      |=> rsp_valid && (rsp_step_count == '0) && !rsp_step_detected)
      else $error("clear beat did not zero the step count");

   a_vib_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_vibrating |=> !rsp_step_detected)
      else $error("step counted while vibrating");

   a_thr_bound: assert property (@(posedge clock) disable iff (reset)
      (y_thr <= THR_BITS'(THR_LIMIT)) && (z_thr <= THR_BITS'(THR_LIMIT)))
      else $error("adaptive threshold out of range");

   a_step_counts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_SAMPLE) && rsp_valid && rsp_ready
      && (rsp_step_count != {COUNT_BITS{1'b1}})
      |=> !rsp_step_detected || (rsp_step_count == $past(rsp_step_count) + 1'b1))
      else $error("detected step did not advance the count");

endmodule

/* hw/rtl/sd_mag_lane.sv */
module sd_mag_lane #(
   parameter int SAMPLE_BITS = sd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic        [SAMPLE_BITS-1:0] mag_change
);
   import sd_pkg::*;

   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic signed [SAMPLE_BITS-1:0] prev_in;
   logic        [SAMPLE_BITS-1:0] cur_abs;
   logic        [SAMPLE_BITS-1:0] prev_abs;

   // magnitudes; the most negative sample maps to 2^(n-1), which still fits
   always_comb begin
      cur_abs  = sample[SAMPLE_BITS-1]  ? (~sample + 1'b1)  : sample;
      prev_abs = prev_ff[SAMPLE_BITS-1] ? (~prev_ff + 1'b1) : prev_ff;
   end

   // absolute difference of the magnitudes
   always_comb begin
      if (cur_abs >= prev_abs) begin
         mag_change = cur_abs - prev_abs;
      end else begin
         mag_change = prev_abs - cur_abs;
      end
   end

   // previous sample of this axis
   always_comb begin
      prev_in = en ? sample : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

/* hw/rtl/sd_adapt.sv */
module sd_adapt #(
   parameter int SAMPLE_BITS = sd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [SAMPLE_BITS-1:0]        mag_change,
   input  logic [sd_pkg::YZ_BITS-1:0]    yz_min,
   input  logic [sd_pkg::YZ_BITS-1:0]    yz_max,
   input  logic [sd_pkg::ADJ_BITS-1:0]   adjust_step,
   output logic                          qualify,
   output logic [sd_pkg::THR_BITS-1:0]   threshold
);
   import sd_pkg::*;

   localparam int DW = (SAMPLE_BITS > THR_BITS ? SAMPLE_BITS : THR_BITS) + 1;

   logic [THR_BITS-1:0] thr_ff;
   logic [THR_BITS-1:0] thr_in;
   logic [THR_BITS-1:0] clamped;
   logic [THR_BITS-1:0] min_ext;
   logic [THR_BITS-1:0] max_ext;
   logic [DW-1:0]       mag_w;
   logic [DW-1:0]       thr_w;
   logic [DW-1:0]       margin;
   logic                big_change;

   assign threshold = thr_ff;

   // qualify and margin test
   always_comb begin
      mag_w      = DW'(mag_change);
      thr_w      = DW'(thr_ff);
      qualify    = mag_w >= thr_w;
      margin     = mag_w - thr_w;
      big_change = qualify && (margin > DW'(BIG_MARGIN));
   end

   // clamp to the bounds, upper bound tested first, then raise below the top
   always_comb begin
      min_ext = THR_BITS'(yz_min);
      max_ext = THR_BITS'(yz_max);
      if (thr_ff > max_ext) begin
         clamped = max_ext;
      end else if (thr_ff < min_ext) begin
         clamped = min_ext;
      end else begin
         clamped = thr_ff;
      end
      thr_in = thr_ff;
      if (en && big_change) begin
         if (clamped < max_ext) begin
            thr_in = clamped + THR_BITS'(adjust_step);
         end else begin
            thr_in = clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_BITS'(YZ_RESET);
      end else begin
         thr_ff <= thr_in;
      end
   end

endmodule

/* hw/rtl/sd_merge.sv */
module sd_merge #(
   parameter int COUNT_BITS = sd_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sd_pkg::merge_ctrl_type       ctrl,
   input  logic                         rsp_ready,
   output logic                         slot_free,
   output logic                         rsp_valid,
   output logic [COUNT_BITS-1:0]        rsp_step_count,
   output logic                         rsp_step_detected
);
   import sd_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  detected_ff;
   logic                  detected_in;
   logic                  step;

   // result slot frees when empty or taken this cycle
   assign slot_free         = !valid_ff || rsp_ready;
   assign rsp_valid         = valid_ff;
   assign rsp_step_count    = count_ff;
   assign rsp_step_detected = detected_ff;

   // combine lane results into a step decision and the saturating count
   always_comb begin
      step        = ctrl.vx && (ctrl.vy || ctrl.vz) && !ctrl.vib;
      count_in    = count_ff;
      detected_in = detected_ff;
      valid_in    = valid_ff && !rsp_ready;
      if (ctrl.fire) begin
         valid_in = 1'b1;
         if (ctrl.clear) begin
            count_in    = '0;
            detected_in = 1'b0;
         end else begin
            detected_in = step;
            if (step && (count_ff != {COUNT_BITS{1'b1}})) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      detected_ff <= detected_in;
   end

endmodule
